### sv/mrr_pkg.sv
// shared types, constants and the crc-16 byte update for the modbus response receiver
`timescale 1ns / 1ps

package mrr_pkg;

  localparam int MaxFrameBytes = 256;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  ExpectedCountReset = 8'h02;
  localparam logic [8:0]  MinFrameLen = 9'd5;

  localparam logic KindData    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam logic ModeByte    = 1'b0;
  localparam logic ModeTimeout = 1'b1;

  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusCrcError   = 2'd1;
  localparam logic [1:0] StatusMismatch   = 2'd2;
  localparam logic [1:0] StatusIncomplete = 2'd3;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [15:0] data_word;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // one byte of crc-16/modbus, eight shift steps unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### sv/modbus_rtu_response_receiver.sv
// modbus rtu response receiver: byte input, crc-16 check, register words and frame verdict
// pipeline: an accepted beat is held in the input stage reg, and its result in the output register
// throughput: one beat per cycle unless stalled; the byte-wise crc update sits between input and result regs
// an output stall holds both stages, and the input stalls only when its stage is full
// reset (rst, synchronous): frame state to start of frame, crc to 0xffff, byte count reg to 2
`timescale 1ns / 1ps

module modbus_rtu_response_receiver import mrr_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [15:0] data_word,
  output logic [1:0]  status,
  output logic        last
);

  logic [7:0] expected_count;
  logic       stage_valid;
  logic       stage_mode;
  logic [7:0] stage_byte;
  logic       advance;
  logic       fire;
  result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_count <= ExpectedCountReset;
    end else if (cfg_wen) begin
      expected_count <= cfg_wdata;
    end
  end

  // output register can take a new result when empty or being drained
  assign advance  = !out_valid || !out_stall;
  assign fire     = stage_valid && advance;
  assign in_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_mode <= mode;
      stage_byte <= rx_byte;
    end
  end

  mrr_frame_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .fire                (fire),
    .mode                (stage_mode),
    .rx_byte             (stage_byte),
    .expected_byte_count (expected_count),
    .result              (result)
  );

  mrr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load_en   (advance && (fire || out_valid)),
    .result    (fire ? result : '0),
    .out_valid (out_valid),
    .kind      (kind),
    .data_word (data_word),
    .status    (status),
    .last      (last)
  );

endmodule

### sv/mrr_frame_core.sv
// frame state and per-byte decode: crc, position, length, word pairing, verdict
`timescale 1ns / 1ps

module mrr_frame_core import mrr_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytes
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic          mode,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    expected_byte_count,
  output result_t       result
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam int CMP_W = LEN_W + 1;
  localparam logic [8:0] MaxLen = 9'(MAX_FRAME_BYTES);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [7:0]       held_high_byte, held_high_byte_next;
  logic [7:0]       held_crc_low, held_crc_low_next;
  logic             count_mismatch, count_mismatch_next;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic [8:0]       len_raw;
  logic [8:0]       len_clamped;
  logic [15:0]      crc_upd;
  logic [15:0]      got_crc;
  logic             in_frame;

  assign pos_ext     = CMP_W'(byte_position);
  assign len_ext     = CMP_W'(frame_length);
  assign len_raw     = {1'b0, rx_byte} + MinFrameLen;
  assign len_clamped = (len_raw > MaxLen) ? MaxLen : len_raw;
  assign crc_upd     = crc_byte(running_crc, rx_byte);
  assign got_crc     = {rx_byte, held_crc_low};
  assign in_frame    = (byte_position != '0);

  always_comb begin
    byte_position_next  = byte_position;
    running_crc_next    = running_crc;
    frame_length_next   = frame_length;
    held_high_byte_next = held_high_byte;
    held_crc_low_next   = held_crc_low;
    count_mismatch_next = count_mismatch;
    result              = '0;

    if (mode == ModeTimeout) begin
      if (in_frame) begin
        byte_position_next  = '0;
        running_crc_next    = CrcInit;
        frame_length_next   = LEN_W'(MinFrameLen);
        held_high_byte_next = '0;
        held_crc_low_next   = '0;
        count_mismatch_next = 1'b0;
        result.valid        = 1'b1;
        result.kind         = KindVerdict;
        result.status       = StatusIncomplete;
        result.last         = 1'b1;
      end
    end else if (pos_ext + CMP_W'(1) >= len_ext) begin
      // high crc byte closes the frame; crc error wins over mismatch
      byte_position_next  = '0;
      running_crc_next    = CrcInit;
      frame_length_next   = LEN_W'(MinFrameLen);
      held_high_byte_next = '0;
      held_crc_low_next   = '0;
      count_mismatch_next = 1'b0;
      result.valid        = 1'b1;
      result.kind         = KindVerdict;
      result.last         = 1'b1;
      if (got_crc != running_crc) begin
        result.status = StatusCrcError;
      end else if (count_mismatch) begin
        result.status = StatusMismatch;
      end else begin
        result.status = StatusOk;
      end
    end else begin
      byte_position_next = byte_position + POS_W'(1);
      if (pos_ext + CMP_W'(2) == len_ext) begin
        held_crc_low_next = rx_byte;
      end else begin
        running_crc_next = crc_upd;
        if (pos_ext == CMP_W'(2)) begin
          frame_length_next   = LEN_W'(len_clamped);
          count_mismatch_next = (rx_byte != expected_byte_count);
        end else if (pos_ext >= CMP_W'(3)) begin
          if (byte_position[0]) begin
            held_high_byte_next = rx_byte;
          end else begin
            result.valid     = 1'b1;
            result.kind      = KindData;
            result.data_word = {held_high_byte, rx_byte};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      running_crc    <= CrcInit;
      frame_length   <= LEN_W'(MinFrameLen);
      held_high_byte <= '0;
      held_crc_low   <= '0;
      count_mismatch <= 1'b0;
    end else if (fire) begin
      byte_position  <= byte_position_next;
      running_crc    <= running_crc_next;
      frame_length   <= frame_length_next;
      held_high_byte <= held_high_byte_next;
      held_crc_low   <= held_crc_low_next;
      count_mismatch <= count_mismatch_next;
    end
  end

endmodule

### sv/mrr_out_reg.sv
// result register on the output channel
`timescale 1ns / 1ps

module mrr_out_reg import mrr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load_en,
  input  result_t     result,
  output logic        out_valid,
  output logic        kind,
  output logic [15:0] data_word,
  output logic [1:0]  status,
  output logic        last
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      kind      <= result.kind;
      data_word <= result.data_word;
      status    <= result.status;
      last      <= result.last;
    end
  end

endmodule
